>>> rtl/pffl_pkg.sv
// Package for the page frame free list allocator.
// Holds the codes, the state and result types and the default sizes.
// Depends on nothing; every other file imports it.
package pffl_pkg;

  localparam int DEF_PAGE_COUNT = 4096;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam int CFG_W     = 13;
  localparam int IN_ADDR_W = 32;
  localparam int ADDR_W    = 24;
  localparam int KIND_W    = 2;
  localparam int CODE_W    = 2;
  localparam int ST_W      = 2;

  // request kinds
  localparam logic [KIND_W-1:0] K_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] K_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] K_INIT  = 2'd2;

  // page status codes
  localparam logic [ST_W-1:0] ST_FREE     = 2'd0;
  localparam logic [ST_W-1:0] ST_INUSE    = 2'd1;
  localparam logic [ST_W-1:0] ST_RESERVED = 2'd2;

  // result codes
  localparam logic [CODE_W-1:0] RC_OK  = 2'd0;
  localparam logic [CODE_W-1:0] RC_OOM = 2'd1;
  localparam logic [CODE_W-1:0] RC_BAD = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_INIT,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] addr;
  } res_t;

endpackage

>>> rtl/pffl_ram.sv
// Simple dual port synchronous memory, one write and one read port.
// Read data is registered. Uses pffl_pkg.
module pffl_ram import pffl_pkg::*; #(
  parameter int WIDTH = ST_W,
  parameter int DEPTH = DEF_PAGE_COUNT
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/pffl_ctrl.sv
// Sequencer of the allocator: head and count of the free list, request checks,
// read-modify-write of the status and link memories, init and clearing sweeps.
// Uses pffl_pkg; drives two pffl_ram instances in the top level.
module pffl_ctrl import pffl_pkg::*; #(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [KIND_W-1:0]             kind,
  input  logic [IN_ADDR_W-1:0]          page_address,
  input  logic                          out_free,
  output logic                          post,
  output res_t                          res,
  output logic                          st_rd_en,
  output logic [$clog2(PAGE_COUNT)-1:0] st_rd_addr,
  input  logic [ST_W-1:0]               st_rd_data,
  output logic                          st_wr_en,
  output logic [$clog2(PAGE_COUNT)-1:0] st_wr_addr,
  output logic [ST_W-1:0]               st_wr_data,
  output logic                          lk_rd_en,
  output logic [$clog2(PAGE_COUNT)-1:0] lk_rd_addr,
  input  logic [$clog2(PAGE_COUNT)-1:0] lk_rd_data,
  output logic                          lk_wr_en,
  output logic [$clog2(PAGE_COUNT)-1:0] lk_wr_addr,
  output logic [$clog2(PAGE_COUNT)-1:0] lk_wr_data
);

  localparam int IDX_W = $clog2(PAGE_COUNT);
  localparam int CNT_W = $clog2(PAGE_COUNT + 1);
  localparam int OFF_W = $clog2(PAGE_BYTES);

  state_t             state, state_next;
  logic [CFG_W-1:0]   ffp;
  logic [KIND_W-1:0]  req_kind;
  logic [IDX_W-1:0]   req_idx;
  logic               req_ok;
  logic [CNT_W-1:0]   lim;
  logic [IDX_W-1:0]   sw;
  logic [IDX_W-1:0]   head, head_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  res_t               pend;
  res_t               res_comb;

  logic               accept;
  logic               sw_last;
  logic [IDX_W-1:0]   free_idx;
  logic               aligned;
  logic               in_range;
  logic [CNT_W-1:0]   cfg_limit;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign sw_last  = (sw == IDX_W'(PAGE_COUNT - 1));

  assign free_idx = IDX_W'(page_address >> OFF_W);
  assign aligned  = (page_address[OFF_W-1:0] == '0);
  assign in_range = (33'(page_address >> OFF_W) < 33'(PAGE_COUNT));
  assign cfg_limit = (32'(ffp) > 32'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT) : CNT_W'(ffp);

  // issue both reads on acceptance; data is back in the next cycle
  assign st_rd_en   = accept;
  assign st_rd_addr = free_idx;
  assign lk_rd_en   = accept;
  assign lk_rd_addr = head;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sw_last) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) state_next = (kind == K_INIT) ? S_INIT : S_RMW;
      end
      S_RMW: state_next = out_free ? S_IDLE : S_HOLD;
      S_INIT: begin
        if (sw_last) state_next = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    st_wr_en   = 1'b0;
    st_wr_addr = sw;
    st_wr_data = ST_RESERVED;
    lk_wr_en   = 1'b0;
    lk_wr_addr = sw;
    lk_wr_data = '0;
    post       = 1'b0;
    res_comb   = '{code: RC_OK, addr: '0};
    head_next  = head;
    cnt_next   = cnt;
    unique case (state)
      S_CLEAR: begin
        st_wr_en = 1'b1;
      end
      S_INIT: begin
        st_wr_en   = 1'b1;
        st_wr_data = (CNT_W'(sw) < lim) ? ST_RESERVED : ST_FREE;
        lk_wr_en   = 1'b1;
        lk_wr_data = (CNT_W'(sw) > lim) ? sw - 1'b1 : '0;
        if (sw_last) begin
          post      = out_free;
          head_next = (lim < CNT_W'(PAGE_COUNT)) ? IDX_W'(PAGE_COUNT - 1) : '0;
          cnt_next  = CNT_W'(PAGE_COUNT) - lim;
        end
      end
      S_RMW: begin
        post = out_free;
        unique case (req_kind)
          K_ALLOC: begin
            if (cnt == '0) begin
              res_comb.code = RC_OOM;
            end else begin
              st_wr_en      = 1'b1;
              st_wr_addr    = head;
              st_wr_data    = ST_INUSE;
              head_next     = lk_rd_data;
              cnt_next      = cnt - 1'b1;
              res_comb.addr = ADDR_W'({head, {OFF_W{1'b0}}});
            end
          end
          K_FREE: begin
            if (req_ok && (st_rd_data == ST_INUSE)) begin
              st_wr_en   = 1'b1;
              st_wr_addr = req_idx;
              st_wr_data = ST_FREE;
              lk_wr_en   = 1'b1;
              lk_wr_addr = req_idx;
              lk_wr_data = (cnt != '0) ? head : '0;
              head_next  = req_idx;
              if (cnt != CNT_W'(PAGE_COUNT)) cnt_next = cnt + 1'b1;
            end else begin
              res_comb.code = RC_BAD;
            end
          end
          default: res_comb.code = RC_BAD;
        endcase
      end
      S_HOLD: begin
        post     = out_free;
        res_comb = pend;
      end
      default: ;
    endcase
  end

  assign res = res_comb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ffp   <= '0;
      sw    <= '0;
      head  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      if (cfg_wr_en) ffp <= cfg_data;
      if (state == S_CLEAR || state == S_INIT) begin
        sw <= sw_last ? '0 : sw + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_idx  <= free_idx;
      req_ok   <= aligned && in_range;
      lim      <= cfg_limit;
    end
    if (state == S_RMW || state == S_INIT) pend <= res_comb;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(PAGE_COUNT))
    else $error("free count above page count");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!st_wr_en && !lk_wr_en))
    else $error("memory write while idle");

  a_post_slot: assert property (@(posedge clk) disable iff (rst)
    post |-> out_free)
    else $error("result posted into an occupied output slot");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW && req_kind == K_ALLOC && cnt != '0) |=> (cnt == $past(cnt) - 1'b1))
    else $error("allocate did not pop exactly one page");
`endif

endmodule

>>> rtl/page_frame_free_list_allocator.sv
// Page frame allocator on a LIFO free list held in block memories.
// Top level: output slot, sequencer and the status and link memories.
// Uses pffl_pkg, pffl_ram and pffl_ctrl.
//
// Usage
//   Request channel: in_valid/in_stall with kind and page_address. kind
//   selects allocate, free or init (rebuild of the free list); page_address is
//   looked at only by free. PAGE_BYTES must be a power of two.
//   Result channel: out_valid/out_stall with result_code and
//   allocated_address, one result for every request, in request order.
//   Configuration: first_free_page is written whenever cfg_wr_en is high;
//   write it only while no request is outstanding. Init reserves lower pages.
// Timing
//   Allocate and free: the acceptance cycle reads the status and link
//   memories and the next cycle writes them back and updates head and
//   count. A new request is taken only once the sequencer is idle again,
//   so requests do not overlap.
//   Init sweeps the memories one page a cycle.
// Reset
//   rst clears the list and starts a clearing pass that marks every page
//   reserved; in_stall stays high until it ends.
// Stalls
//   A finished result waits in the output register; the sequencer holds the
//   next result back until the slot is taken, and stalls requests meanwhile.
module page_frame_free_list_allocator import pffl_pkg::*; #(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     first_free_page,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    kind,
  input  logic [IN_ADDR_W-1:0] page_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CODE_W-1:0]    result_code,
  output logic [ADDR_W-1:0]    allocated_address
);

  localparam int IDX_W = $clog2(PAGE_COUNT);

  logic             out_free;
  logic             post;
  res_t             res;

  logic             st_rd_en, st_wr_en;
  logic [IDX_W-1:0] st_rd_addr, st_wr_addr;
  logic [ST_W-1:0]  st_rd_data, st_wr_data;
  logic             lk_rd_en, lk_wr_en;
  logic [IDX_W-1:0] lk_rd_addr, lk_wr_addr;
  logic [IDX_W-1:0] lk_rd_data, lk_wr_data;

  // the slot takes a new result when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  pffl_ctrl #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_data     (first_free_page),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .page_address (page_address),
    .out_free     (out_free),
    .post         (post),
    .res          (res),
    .st_rd_en     (st_rd_en),
    .st_rd_addr   (st_rd_addr),
    .st_rd_data   (st_rd_data),
    .st_wr_en     (st_wr_en),
    .st_wr_addr   (st_wr_addr),
    .st_wr_data   (st_wr_data),
    .lk_rd_en     (lk_rd_en),
    .lk_rd_addr   (lk_rd_addr),
    .lk_rd_data   (lk_rd_data),
    .lk_wr_en     (lk_wr_en),
    .lk_wr_addr   (lk_wr_addr),
    .lk_wr_data   (lk_wr_data)
  );

  // page status: free, in use or reserved
  pffl_ram #(
    .WIDTH (ST_W),
    .DEPTH (PAGE_COUNT)
  ) u_status (
    .clk     (clk),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  // next link of each free page
  pffl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (PAGE_COUNT)
  ) u_link (
    .clk     (clk),
    .rd_en   (lk_rd_en),
    .rd_addr (lk_rd_addr),
    .rd_data (lk_rd_data),
    .wr_en   (lk_wr_en),
    .wr_addr (lk_wr_addr),
    .wr_data (lk_wr_data)
  );

  // output slot: load on post, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      result_code       <= res.code;
      allocated_address <= res.addr;
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Testbench for page_frame_free_list_allocator: a directed table, then random
// allocate, free and init traffic, with every result checked in order.
// Depends on rtl/pffl_pkg.sv and rtl/page_frame_free_list_allocator.sv.
module testbench;
  import pffl_pkg::*;

  localparam int PAGES       = DEF_PAGE_COUNT;
  localparam int PBYTES      = DEF_PAGE_BYTES;
  localparam int IDLE_LIMIT  = 30000;  // init sweep plus clearing pass, several times over
  localparam int LONG_HOLD   = 400;
  localparam int N_DIRECTED  = 25;
  localparam int N_PHASES    = 9;
  localparam int PHASE_ITEMS = 114;
  localparam int REPORT_CAP  = 10;

  // the request kind that the block does not define
  localparam logic [KIND_W-1:0] K_UNUSED = 2'd3;

  // One row of the directed table. Where exact is set, code and ret are the
  // typed-in result; otherwise the result comes from the shadow allocator.
  typedef struct {
    bit                   set_cfg;
    logic [CFG_W-1:0]     cfg;
    logic [KIND_W-1:0]    kind;
    logic [IN_ADDR_W-1:0] addr;
    bit                   exact;
    logic [CODE_W-1:0]    code;
    logic [ADDR_W-1:0]    ret;
  } stim_row_t;

  // Every input starts from a known value; later changes come at clock edges.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     first_free_page = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    kind = '0;
  logic [IN_ADDR_W-1:0] page_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic [CODE_W-1:0]    result_code;
  logic [ADDR_W-1:0]    allocated_address;

  // Shadow copy of the allocator: page status, links, head and free count.
  logic [ST_W-1:0]  shadow_status [PAGES];
  logic [CFG_W-1:0] shadow_link [PAGES];
  logic [CFG_W-1:0] shadow_head;
  int               shadow_count;
  logic [CFG_W-1:0] shadow_first_free;
  int               held_pages [$];     // pages currently in use, for valid frees
  res_t             pending_results [$];

  stim_row_t directed_rows [N_DIRECTED];

  int  send_calm;
  int  recv_calm;
  bit  hold_off_req;
  int  mismatch_count;
  int  report_count;
  int  n_sent;
  int  n_alloc;
  int  n_oom;
  int  n_freed;
  int  n_bad;
  int  n_init;

  page_frame_free_list_allocator uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .first_free_page   (first_free_page),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .page_address      (page_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_code       (result_code),
    .allocated_address (allocated_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draw a random wait; now and then start a stretch with no waits.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Push a page on top of the shadow free list.
  function automatic void push_free_page(int idx);
    shadow_link[idx] = (shadow_count > 0) ? shadow_head : '0;
    shadow_head = CFG_W'(idx);
    if (shadow_count < PAGES) shadow_count++;
  endfunction

  // Apply one request to the shadow allocator and return the result it gives.
  function automatic res_t predict_page_result(logic [KIND_W-1:0] k,
                                               logic [IN_ADDR_W-1:0] a);
    res_t r;
    int   idx;
    int   lim;
    int   j;
    r.code = RC_OK;
    r.addr = '0;
    case (k)
      K_ALLOC: begin
        if (shadow_count == 0) begin
          r.code = RC_OOM;
          n_oom++;
        end else begin
          // pop the head; its link was written when the page was pushed
          idx = int'(shadow_head);
          shadow_count--;
          shadow_head = shadow_link[idx];
          shadow_status[idx] = ST_INUSE;
          r.addr = ADDR_W'(idx * PBYTES);
          held_pages.push_back(idx);
          n_alloc++;
        end
      end
      K_FREE: begin
        // misaligned, out of range or not in use: reject with no change
        if ((a % IN_ADDR_W'(PBYTES)) != '0 || 64'(a) >= 64'(PAGES) * 64'(PBYTES)) begin
          r.code = RC_BAD;
        end else begin
          idx = int'(a / IN_ADDR_W'(PBYTES));
          if (shadow_status[idx] != ST_INUSE) begin
            r.code = RC_BAD;
          end else begin
            shadow_status[idx] = ST_FREE;
            push_free_page(idx);
            for (j = 0; j < held_pages.size(); j++) begin
              if (held_pages[j] == idx) begin
                held_pages.delete(j);
                break;
              end
            end
            n_freed++;
          end
        end
      end
      K_INIT: begin
        // rebuild from empty; a first free page beyond the pages saturates
        lim = (int'(shadow_first_free) > PAGES) ? PAGES : int'(shadow_first_free);
        shadow_count = 0;
        shadow_head = '0;
        for (j = 0; j < lim; j++) begin
          shadow_status[j] = ST_RESERVED;
          shadow_link[j] = '0;
        end
        for (j = lim; j < PAGES; j++) begin
          shadow_status[j] = ST_FREE;
          push_free_page(j);
        end
        held_pages.delete();
        n_init++;
      end
      default: r.code = RC_BAD;
    endcase
    if (r.code == RC_BAD) n_bad++;
    return r;
  endfunction

  // Offer one request after a drawn gap, hold it until taken, then record
  // the result it must produce.
  task automatic offer_request(input logic [KIND_W-1:0] k, input logic [IN_ADDR_W-1:0] a,
                               input bit exact, input res_t typed);
    int   gap;
    res_t predicted;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    page_address <= a;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_page_result(k, a);
    pending_results.push_back(exact ? typed : predicted);
    n_sent++;
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write the first free page register while the block is idle.
  task automatic write_first_free(input logic [CFG_W-1:0] v);
    wait_all_results();
    cfg_wr_en       <= 1'b1;
    first_free_page <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_first_free = v;
  endtask

  // Random request: mostly allocates and frees of pages in use, with some
  // broken frees, unused kinds and the odd rebuild mixed in.
  task automatic offer_random_request();
    logic [KIND_W-1:0]    k;
    logic [IN_ADDR_W-1:0] a;
    int                   pick;
    int                   page;
    res_t                 none;
    none = '0;
    pick = $urandom_range(0, 99);
    a = $urandom;
    if (pick < 46) begin
      k = K_ALLOC;
    end else if (pick < 96) begin
      k = K_FREE;
      if (held_pages.size() > 0) page = held_pages[$urandom_range(0, held_pages.size() - 1)];
      else page = $urandom_range(0, PAGES - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: a = page * PBYTES;
        6:       a = page * PBYTES + $urandom_range(1, PBYTES - 1);
        7:       a = a | IN_ADDR_W'(PAGES * PBYTES);
        8:       a = $urandom_range(0, PAGES - 1) * PBYTES;
        default: ;
      endcase
    end else if (pick < 99) begin
      k = K_UNUSED;
    end else begin
      k = K_INIT;
    end
    offer_request(k, a, 1'b0, none);
  endtask

  // Result side: stall for a drawn number of cycles, then take one result
  // and compare it field by field with the oldest expectation.
  initial begin : result_sink
    int   hold;
    res_t want;
    forever begin
      hold = draw_wait(recv_calm);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        report_count++;
        if (report_count <= REPORT_CAP)
          $display("unexpected result: code %0d addr %h", result_code, allocated_address);
      end else begin
        want = pending_results.pop_front();
        if (result_code !== want.code || allocated_address !== want.addr) begin
          mismatch_count++;
          report_count++;
          if (report_count <= REPORT_CAP)
            $display("result mismatch: code exp %0d got %0d, addr exp %h got %h",
                     want.code, result_code, want.addr, allocated_address);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : request_source
    int               row;
    int               ph;
    int               n;
    res_t             typed;
    logic [CFG_W-1:0] phase_cfg [N_PHASES];

    // shadow state after reset: every page reserved, list empty
    for (n = 0; n < PAGES; n++) begin
      shadow_status[n] = ST_RESERVED;
      shadow_link[n] = '0;
    end
    shadow_head = '0;
    shadow_count = 0;
    shadow_first_free = '0;

    // Directed table: set_cfg, cfg, kind, addr, exact, code, ret
    directed_rows[0]  = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b1, RC_OOM, 24'h0};
    directed_rows[1]  = '{1'b0, 13'd0,    K_FREE,   32'h0000_0000, 1'b1, RC_BAD, 24'h0};
    directed_rows[2]  = '{1'b0, 13'd0,    K_UNUSED, 32'hFFFF_FFFF, 1'b1, RC_BAD, 24'h0};
    // two pages left at the top; pop both, the second being the last
    directed_rows[3]  = '{1'b1, 13'd4094, K_INIT,   32'hFFFF_FFFF, 1'b1, RC_OK,  24'h0};
    directed_rows[4]  = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b1, RC_OK,  24'hFFF000};
    directed_rows[5]  = '{1'b0, 13'd0,    K_ALLOC,  32'hFFFF_FFFF, 1'b1, RC_OK,  24'hFFE000};
    directed_rows[6]  = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b1, RC_OOM, 24'h0};
    directed_rows[7]  = '{1'b0, 13'd0,    K_FREE,   32'h00FF_F000, 1'b1, RC_OK,  24'h0};
    // double free, misaligned, out of range, all ones, reserved page
    directed_rows[8]  = '{1'b0, 13'd0,    K_FREE,   32'h00FF_F000, 1'b1, RC_BAD, 24'h0};
    directed_rows[9]  = '{1'b0, 13'd0,    K_FREE,   32'h00FF_E001, 1'b1, RC_BAD, 24'h0};
    directed_rows[10] = '{1'b0, 13'd0,    K_FREE,   32'h0100_0000, 1'b1, RC_BAD, 24'h0};
    directed_rows[11] = '{1'b0, 13'd0,    K_FREE,   32'hFFFF_FFFF, 1'b1, RC_BAD, 24'h0};
    directed_rows[12] = '{1'b0, 13'd0,    K_FREE,   32'h0000_0000, 1'b1, RC_BAD, 24'h0};
    directed_rows[13] = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b1, RC_OK,  24'hFFF000};
    // first free page beyond the pages saturates, and exactly at the end
    directed_rows[14] = '{1'b1, 13'd8191, K_INIT,   32'h0000_0000, 1'b1, RC_OK,  24'h0};
    directed_rows[15] = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b1, RC_OOM, 24'h0};
    directed_rows[16] = '{1'b1, 13'd4096, K_INIT,   32'h0000_0000, 1'b1, RC_OK,  24'h0};
    directed_rows[17] = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b1, RC_OOM, 24'h0};
    // whole memory free; page 0 is free, not in use
    directed_rows[18] = '{1'b1, 13'd0,    K_INIT,   32'h0000_0000, 1'b1, RC_OK,  24'h0};
    directed_rows[19] = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b1, RC_OK,  24'hFFF000};
    directed_rows[20] = '{1'b0, 13'd0,    K_FREE,   32'h0000_0000, 1'b1, RC_BAD, 24'h0};
    directed_rows[21] = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b0, RC_OK,  24'h0};
    directed_rows[22] = '{1'b0, 13'd0,    K_FREE,   32'h00FF_F000, 1'b0, RC_OK,  24'h0};
    directed_rows[23] = '{1'b0, 13'd0,    K_ALLOC,  32'h0000_0000, 1'b0, RC_OK,  24'h0};
    directed_rows[24] = '{1'b0, 13'd0,    K_FREE,   32'hFFFF_F000, 1'b1, RC_BAD, 24'h0};

    // register settings for the random phases, extremes first
    phase_cfg[0] = 13'd0;
    phase_cfg[1] = 13'd4090;
    phase_cfg[2] = 13'd8191;
    phase_cfg[3] = 13'd4096;
    phase_cfg[4] = 13'd1;
    phase_cfg[5] = 13'd4095;
    phase_cfg[6] = CFG_W'($urandom_range(0, PAGES));
    phase_cfg[7] = CFG_W'($urandom);
    phase_cfg[8] = CFG_W'($urandom_range(0, PAGES));

    // hold reset, then release it once
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < N_DIRECTED; row++) begin
      if (directed_rows[row].set_cfg) write_first_free(directed_rows[row].cfg);
      typed.code = directed_rows[row].code;
      typed.addr = directed_rows[row].ret;
      offer_request(directed_rows[row].kind, directed_rows[row].addr,
                    directed_rows[row].exact, typed);
    end

    typed = '0;
    for (ph = 0; ph < N_PHASES; ph++) begin
      // reconfigure while idle, then rebuild the list from the new setting
      write_first_free(phase_cfg[ph]);
      offer_request(K_INIT, $urandom, 1'b0, typed);
      if (ph == 0) begin
        // stall results for a long stretch and keep requests coming back to
        // back, so the output slot fills and the block stalls its input
        send_calm = 60;
        hold_off_req = 1'b1;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // pause the sender until the block has drained completely
        if (ph == 6 && n == PHASE_ITEMS / 2) wait_all_results();
        offer_random_request();
      end
    end

    // drain, then wait on so that any stray result would show
    wait_all_results();
    repeat (20) @(posedge clk);
    mismatch_count += pending_results.size();

    $display("%0d requests: %0d allocations, %0d out of memory, %0d frees, %0d rejected,",
             n_sent, n_alloc, n_oom, n_freed, n_bad);
    $display("%0d list rebuilds over %0d first free page settings; %0d mismatches",
             n_init, N_PHASES + 4, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
